### rtl/core/lpr_pkg.sv
// Shared types and codes for the line pixel rasterizer.
`default_nettype none

package lpr_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_X_OFFSET    = 3'd0,
    CFG_Y_OFFSET    = 3'd1,
    CFG_BPP         = 3'd2,
    CFG_LINE_STRIDE = 3'd3
  } cfg_index_t;

  // Input word kinds carried in tuser
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  // Axis step direction codes
  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd3
  } dir_t;

  localparam int unsigned FIELD_BITS   = 16;
  localparam int unsigned ADDR_BITS    = 34;
  localparam int unsigned BPP_BITS     = 6;
  localparam int unsigned BYTE_SHIFT   = 3;
  localparam logic [BPP_BITS-1:0] BPP_RESET = 6'd24;

endpackage : lpr_pkg

`default_nettype wire

### rtl/core/line_pixel_rasterizer.sv
// Line pixel rasterizer: start words load a line, step words emit one pixel while busy.
// The pixel is registered and reaches the master side in the cycle after acceptance.
// Throughput: one word per cycle while the master side accepts; a pixel waiting in the
// output register holds off the slave side until it is taken.
// Reset: synchronous; the line is idle, the output is empty, depth returns to 24 bpp.
`default_nettype none

module line_pixel_rasterizer
  import lpr_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave side
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // x_start, y_start, x_end, y_end
  input  wire logic        s_tuser,   // action
  // master side
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // pixel_x, pixel_y, byte_address, zero pad
  output logic             m_tlast,   // last_pixel
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned ERR_BITS  = COORD_BITS + 2;
  localparam int unsigned LEFT_BITS = COORD_BITS + 1;
  localparam int unsigned SUM_BITS  = FIELD_BITS + 1;

  // configuration registers
  logic [FIELD_BITS-1:0] x_offset;
  logic [FIELD_BITS-1:0] y_offset;
  logic [BPP_BITS-1:0]   pixel_depth;
  logic [FIELD_BITS-1:0] line_stride;

  // line state
  logic [COORD_BITS-1:0] cur_col, cur_col_next;
  logic [COORD_BITS-1:0] cur_row, cur_row_next;
  logic [ERR_BITS-1:0]   col_error, col_error_next;
  logic [ERR_BITS-1:0]   row_error, row_error_next;
  logic [COORD_BITS-1:0] abs_dx, abs_dx_next;
  logic [COORD_BITS-1:0] abs_dy, abs_dy_next;
  logic [COORD_BITS-1:0] major_len, major_len_next;
  dir_t                  col_dir, col_dir_next;
  dir_t                  row_dir, row_dir_next;
  logic [LEFT_BITS-1:0]  pixels_left, pixels_left_next;
  logic                  busy, busy_next;

  // output register
  logic [FIELD_BITS-1:0] pixel_x;
  logic [FIELD_BITS-1:0] pixel_y;
  logic [ADDR_BITS-1:0]  byte_address;
  logic                  last_pixel;

  logic                  in_fire;
  logic                  emit;
  logic [COORD_BITS-1:0] xs, ys, xe, ye;
  logic [LEFT_BITS-1:0]  left_dec;
  logic [ERR_BITS:0]     col_sum, row_sum;
  logic [SUM_BITS-1:0]   col_pos, row_pos;
  logic [SUM_BITS+2:0]   col_term;
  logic [ADDR_BITS-1:0]  row_term;
  logic [ADDR_BITS-1:0]  addr_sum;

  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign emit      = in_fire && (s_tuser == ACT_STEP) && busy;

  assign xs = s_tdata[COORD_BITS-1:0];
  assign ys = s_tdata[16 +: COORD_BITS];
  assign xe = s_tdata[32 +: COORD_BITS];
  assign ye = s_tdata[48 +: COORD_BITS];

  // Step one coordinate by its direction code
  function automatic logic [COORD_BITS-1:0] advance(input logic [COORD_BITS-1:0] pos,
                                                    input dir_t dir);
    logic [COORD_BITS-1:0] res;
    case (dir)
      DIR_PLUS:  res = pos + COORD_BITS'(1);
      DIR_MINUS: res = pos - COORD_BITS'(1);
      default:   res = pos;
    endcase
    return res;
  endfunction

  // Build the byte address from the current position
  always_comb begin
    col_pos  = SUM_BITS'(cur_col) + SUM_BITS'(x_offset);
    row_pos  = SUM_BITS'(cur_row) + SUM_BITS'(y_offset);
    col_term = (SUM_BITS+3)'(col_pos) * (SUM_BITS+3)'(pixel_depth >> BYTE_SHIFT);
    row_term = ADDR_BITS'(row_pos) * ADDR_BITS'(line_stride);
    addr_sum = ADDR_BITS'(col_term) + row_term;
  end

  // Next line state for start and step words
  always_comb begin
    cur_col_next     = cur_col;
    cur_row_next     = cur_row;
    col_error_next   = col_error;
    row_error_next   = row_error;
    abs_dx_next      = abs_dx;
    abs_dy_next      = abs_dy;
    major_len_next   = major_len;
    col_dir_next     = col_dir;
    row_dir_next     = row_dir;
    pixels_left_next = pixels_left;
    busy_next        = busy;
    left_dec         = pixels_left - LEFT_BITS'(1);
    col_sum          = (ERR_BITS+1)'(col_error) + (ERR_BITS+1)'(abs_dx);
    row_sum          = (ERR_BITS+1)'(row_error) + (ERR_BITS+1)'(abs_dy);

    if (in_fire && s_tuser == ACT_START) begin
      if (xe > xs) begin
        abs_dx_next  = xe - xs;
        col_dir_next = DIR_PLUS;
      end else if (xe < xs) begin
        abs_dx_next  = xs - xe;
        col_dir_next = DIR_MINUS;
      end else begin
        abs_dx_next  = '0;
        col_dir_next = DIR_NONE;
      end
      if (ye > ys) begin
        abs_dy_next  = ye - ys;
        row_dir_next = DIR_PLUS;
      end else if (ye < ys) begin
        abs_dy_next  = ys - ye;
        row_dir_next = DIR_MINUS;
      end else begin
        abs_dy_next  = '0;
        row_dir_next = DIR_NONE;
      end
      major_len_next   = (abs_dx_next > abs_dy_next) ? abs_dx_next : abs_dy_next;
      cur_col_next     = xs;
      cur_row_next     = ys;
      col_error_next   = '0;
      row_error_next   = '0;
      pixels_left_next = LEFT_BITS'(major_len_next) + LEFT_BITS'(2);
      busy_next        = 1'b1;
    end else if (emit) begin
      pixels_left_next = left_dec;
      if (col_sum > (ERR_BITS+1)'(major_len)) begin
        col_error_next = ERR_BITS'(col_sum - (ERR_BITS+1)'(major_len));
        cur_col_next   = advance(cur_col, col_dir);
      end else begin
        col_error_next = ERR_BITS'(col_sum);
      end
      if (row_sum > (ERR_BITS+1)'(major_len)) begin
        row_error_next = ERR_BITS'(row_sum - (ERR_BITS+1)'(major_len));
        cur_row_next   = advance(cur_row, row_dir);
      end else begin
        row_error_next = ERR_BITS'(row_sum);
      end
      if (left_dec == '0) begin
        busy_next = 1'b0;
      end
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset    <= '0;
      y_offset    <= '0;
      pixel_depth <= BPP_RESET;
      line_stride <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_X_OFFSET:    x_offset    <= cfg_data;
        CFG_Y_OFFSET:    y_offset    <= cfg_data;
        CFG_BPP:         pixel_depth <= cfg_data[BPP_BITS-1:0];
        CFG_LINE_STRIDE: line_stride <= cfg_data;
        default:         ;
      endcase
    end
  end

  // Hold line state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col     <= '0;
      cur_row     <= '0;
      col_error   <= '0;
      row_error   <= '0;
      abs_dx      <= '0;
      abs_dy      <= '0;
      major_len   <= '0;
      col_dir     <= DIR_NONE;
      row_dir     <= DIR_NONE;
      pixels_left <= '0;
      busy        <= 1'b0;
    end else begin
      cur_col     <= cur_col_next;
      cur_row     <= cur_row_next;
      col_error   <= col_error_next;
      row_error   <= row_error_next;
      abs_dx      <= abs_dx_next;
      abs_dy      <= abs_dy_next;
      major_len   <= major_len_next;
      col_dir     <= col_dir_next;
      row_dir     <= row_dir_next;
      pixels_left <= pixels_left_next;
      busy        <= busy_next;
    end
  end

  // Advance the output word
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Capture pixel payload
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x      <= FIELD_BITS'(cur_col);
      pixel_y      <= FIELD_BITS'(cur_row);
      byte_address <= addr_sum;
      last_pixel   <= (left_dec == '0);
    end
  end

  assign m_tdata = {6'd0, byte_address, pixel_y, pixel_x};
  assign m_tlast = last_pixel;

endmodule : line_pixel_rasterizer

`default_nettype wire
